/* rtl/tllf_pkg.sv */
// tllf_pkg: shared types and constants of the tagged log line filter
// no dependencies
`timescale 1ns / 1ps

package tllf_pkg;

  localparam int LINE_MAX_DEF = 64;
  localparam int LOG_MAX_DEF  = 1048576;
  localparam int KEPT_TOTAL_W = 21;

  localparam logic [7:0]  BYTE_CR = 8'h0D;
  localparam logic [7:0]  BYTE_LF = 8'h0A;
  // seven tag bytes, oldest in the top byte
  localparam logic [55:0] TAG_SEQ = 56'h5B48424F4F545D;
  // tag plus cr
  localparam int TAG_SPAN = 8;
  localparam int SEEN_W   = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_CR,
    ST_LF
  } state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_body;
    logic load_cr;
    logic load_lf;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic start_emit;
    logic body_empty;
    logic body_last;
  } dp_sts_t;

endpackage

/* rtl/tllf_ram.sv */
// tllf_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tllf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tllf_ctrl.sv */
// tllf_ctrl: controller state machine for intake and kept line replay
// depends on tllf_pkg
`timescale 1ns / 1ps

module tllf_ctrl
  import tllf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && (state_q == ST_IDLE) && sts_i.slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && sts_i.start_emit) begin
          state_d = sts_i.body_empty ? ST_CR : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.slot_free) begin
          state_d = sts_i.body_last ? ST_CR : ST_READ;
        end
      end
      ST_CR: begin
        if (sts_i.slot_free) begin
          state_d = ST_LF;
        end
      end
      ST_LF: begin
        if (sts_i.slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = accept;
        in_stall_o   = !sts_i.slot_free;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      ST_LOAD: begin
        cmd_o.load_body = sts_i.slot_free;
      end
      ST_CR: begin
        cmd_o.load_cr = sts_i.slot_free;
      end
      ST_LF: begin
        cmd_o.load_lf = sts_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_LOAD)
    else $error("read not followed by load");

  a_cr_then_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_cr |=> state_q == ST_LF)
    else $error("cr beat not followed by lf");

  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.load_body, cmd_o.load_cr, cmd_o.load_lf}))
    else $error("more than one output source");

endmodule

/* rtl/tllf_dp.sv */
// tllf_dp: datapath with line store, tag window, counters and output register
// depends on tllf_pkg and tllf_ram
`timescale 1ns / 1ps

module tllf_dp
  import tllf_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  parameter int LOG_MAX  = LOG_MAX_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output dp_sts_t                 sts_o,
  input  logic [7:0]              in_byte_i,
  input  logic                    end_of_log_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    byte_valid_o,
  output logic                    last_of_run_o,
  output logic                    log_done_o,
  output logic [KEPT_TOTAL_W-1:0] kept_total_o,
  output logic                    line_dropped_o
);

  localparam int FILL_W = $clog2(LINE_MAX + 1);
  localparam int IDX_W  = $clog2(LINE_MAX);
  localparam int KEPT_W = $clog2(LOG_MAX + 1);

  logic              filter_en_q;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [63:0]       recent_q, recent_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [KEPT_W-1:0] kept_q, kept_d, kept_inc;
  logic              eol_q;
  logic [FILL_W-1:0] body_len_q;
  logic [IDX_W-1:0]  idx_q;

  logic                     out_valid_q, out_valid_d;
  logic [7:0]               out_byte_q, out_byte_d;
  logic                     byte_valid_q, byte_valid_d;
  logic                     last_q, last_d;
  logic                     done_q, done_d;
  logic [KEPT_TOTAL_W-1:0]  total_q, total_d;
  logic                     dropped_q, dropped_d;

  logic                     ends_line, drop_line, tag_hit, start_emit;
  logic                     store_ok, ovf_new, mark_drop;
  logic                     acc_load, byte_load, log_clear, slot_free;
  logic                     ram_we;
  logic [7:0]               ram_rdata;
  logic [KEPT_W+KEPT_TOTAL_W-1:0] kept_ext;
  logic [KEPT_TOTAL_W-1:0]  kept_out;

  tllf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_MAX)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (in_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // line classification
  assign ends_line  = (in_byte_i == BYTE_LF) && (recent_q[7:0] == BYTE_CR);
  assign drop_line  = ovf_q || (fill_q == FILL_W'(LINE_MAX));
  assign tag_hit    = (fill_q >= FILL_W'(TAG_SPAN)) && (seen_q == SEEN_W'(TAG_SPAN))
                      && (recent_q[63:8] == TAG_SEQ);
  assign start_emit = filter_en_q && ends_line && !drop_line && tag_hit;
  assign store_ok   = fill_q < FILL_W'(LINE_MAX);
  assign ovf_new    = ovf_q || !store_ok;
  assign mark_drop  = ends_line ? drop_line : ovf_new;

  assign ram_we = cmd_i.accept && filter_en_q && !ends_line && store_ok;

  assign acc_load  = cmd_i.accept && (!filter_en_q || (ends_line && drop_line)
                     || (end_of_log_i && !start_emit));
  assign byte_load = (acc_load && !filter_en_q) || cmd_i.load_body || cmd_i.load_cr
                     || cmd_i.load_lf;
  assign log_clear = (cmd_i.accept && end_of_log_i && !start_emit)
                     || (cmd_i.load_lf && eol_q);
  assign slot_free = !out_valid_q || !out_stall_i;

  assign kept_inc = (kept_q == KEPT_W'(LOG_MAX)) ? kept_q : kept_q + KEPT_W'(1);
  assign kept_ext = {{KEPT_TOTAL_W{1'b0}}, kept_inc};
  assign kept_out = kept_ext[KEPT_TOTAL_W-1:0];

  assign sts_o.slot_free  = slot_free;
  assign sts_o.start_emit = start_emit;
  assign sts_o.body_empty = fill_q == FILL_W'(TAG_SPAN);
  assign sts_o.body_last  = (FILL_W'(idx_q) + FILL_W'(1)) == body_len_q;

  // log state
  always_comb begin
    fill_d   = fill_q;
    ovf_d    = ovf_q;
    recent_d = recent_q;
    seen_d   = seen_q;
    kept_d   = kept_q;
    if (cmd_i.accept) begin
      recent_d = {recent_q[55:0], in_byte_i};
      if (seen_q != SEEN_W'(TAG_SPAN)) begin
        seen_d = seen_q + SEEN_W'(1);
      end
      if (!filter_en_q || ends_line) begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end else if (store_ok) begin
        fill_d = fill_q + FILL_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (byte_load) begin
      kept_d = kept_inc;
    end
    if (log_clear) begin
      kept_d = '0;
    end
    if (cmd_i.accept && end_of_log_i) begin
      fill_d   = '0;
      ovf_d    = 1'b0;
      recent_d = '0;
      seen_d   = '0;
    end
  end

  // output register
  always_comb begin
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    last_d       = last_q;
    done_d       = done_q;
    total_d      = total_q;
    dropped_d    = dropped_q;
    out_valid_d  = out_valid_q && out_stall_i;
    if (acc_load) begin
      out_valid_d  = 1'b1;
      last_d       = 1'b1;
      done_d       = end_of_log_i;
      if (!filter_en_q) begin
        out_byte_d   = in_byte_i;
        byte_valid_d = 1'b1;
        total_d      = kept_out;
        dropped_d    = 1'b0;
      end else begin
        out_byte_d   = '0;
        byte_valid_d = 1'b0;
        total_d      = KEPT_TOTAL_W'(kept_q);
        dropped_d    = mark_drop;
      end
    end else if (cmd_i.load_body || cmd_i.load_cr || cmd_i.load_lf) begin
      out_valid_d  = 1'b1;
      byte_valid_d = 1'b1;
      total_d      = kept_out;
      dropped_d    = 1'b0;
      last_d       = cmd_i.load_lf;
      done_d       = cmd_i.load_lf && eol_q;
      priority if (cmd_i.load_body) begin
        out_byte_d = ram_rdata;
      end else if (cmd_i.load_cr) begin
        out_byte_d = BYTE_CR;
      end else begin
        out_byte_d = BYTE_LF;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b1;
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      recent_q    <= '0;
      seen_q      <= '0;
      kept_q      <= '0;
      eol_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        filter_en_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      recent_q    <= recent_d;
      seen_q      <= seen_d;
      kept_q      <= kept_d;
      out_valid_q <= out_valid_d;
      if (cmd_i.accept && start_emit) begin
        eol_q <= end_of_log_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && start_emit) begin
      body_len_q <= fill_q - FILL_W'(TAG_SPAN);
      idx_q      <= '0;
    end else if (cmd_i.load_body) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    last_q       <= last_d;
    done_q       <= done_d;
    total_q      <= total_d;
    dropped_q    <= dropped_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign byte_valid_o   = byte_valid_q;
  assign last_of_run_o  = last_q;
  assign log_done_o     = done_q;
  assign kept_total_o   = total_q;
  assign line_dropped_o = dropped_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(LINE_MAX))
    else $error("line fill beyond store");

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KEPT_W'(LOG_MAX))
    else $error("kept count beyond limit");

  a_body_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_body |-> (FILL_W'(idx_q) < body_len_q))
    else $error("body read past line end");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_lf && eol_q) |=> (kept_q == '0) && (fill_q == '0))
    else $error("log state not cleared at log end");

endmodule

/* rtl/tagged_log_line_filter_core.sv */
// tagged_log_line_filter_core: top level of the tagged log line filter
// depends on tllf_pkg, tllf_ctrl, tllf_dp and tllf_ram
//
//  channel | signals                                              | dir
//  in      | in_valid_i, in_stall_o, in_byte_i, end_of_log_i      | in
//  out     | out_valid_o, out_stall_i, out_byte_o, byte_valid_o,  | out
//          | last_of_run_o, log_done_o, kept_total_o,              |
//          | line_dropped_o                                        |
//  cfg     | cfg_we_i, cfg_wdata_i (filter_enable)                | in
//
// a byte that makes at most one beat is taken in the idle state while the output slot is free
// a kept line holds intake after its lf while the controller steps through read and load
// for each body byte from the line store's registered read port, then the cr and lf beats
// reset puts the block idle with filtering on; no clearing pass is needed
// intake waits while a stalled output beat is held
`timescale 1ns / 1ps

module tagged_log_line_filter_core
  import tllf_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  parameter int LOG_MAX  = LOG_MAX_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              in_byte_i,
  input  logic                    end_of_log_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [7:0]              out_byte_o,
  output logic                    byte_valid_o,
  output logic                    last_of_run_o,
  output logic                    log_done_o,
  output logic [KEPT_TOTAL_W-1:0] kept_total_o,
  output logic                    line_dropped_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_wdata_i
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  tllf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tllf_dp #(
    .LINE_MAX (LINE_MAX),
    .LOG_MAX  (LOG_MAX)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_byte_i      (in_byte_i),
    .end_of_log_i   (end_of_log_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .byte_valid_o   (byte_valid_o),
    .last_of_run_o  (last_of_run_o),
    .log_done_o     (log_done_o),
    .kept_total_o   (kept_total_o),
    .line_dropped_o (line_dropped_o)
  );

endmodule
